// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define CHK_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("checker: implication failed");

// Clocked implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("checker: next-cycle implication failed");

`endif

// ----- hdl/u2d_pkg.sv -----
// Shared types and constants for the 64-bit decimal ASCII converter.
package u2d_pkg;

    localparam int MAX_DIGITS_DEF = 20;
    localparam int VALUE_W        = 64;
    localparam int CAP_W          = 5;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int CNT_W          = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NUL  = 8'h00;
    localparam logic [DIGIT_W-1:0] BCD_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_THREE = 4'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CAP_W-1:0]   capacity;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              written;
        logic              last;
    } t_out;

    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic dig_shift;
    } t_cell_ctrl;

endpackage

// ----- hdl/u2d_cell.sv -----
// One BCD digit cell: shift-add-3 step during conversion, digit shift during output.
module u2d_cell (
    input  logic                       i_clk,
    input  u2d_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_bit,
    input  logic [u2d_pkg::DIGIT_W-1:0] i_digit,
    output logic                       o_bit,
    output logic [u2d_pkg::DIGIT_W-1:0] o_digit
);
    import u2d_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    assign adj     = (r_digit >= BCD_FIVE) ? r_digit + BCD_THREE : r_digit;
    assign o_bit   = adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.bit_shift) begin
            n_digit = {adj[DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.dig_shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ----- hdl/uint64_to_decimal_ascii.sv -----
// Top level: 64-bit unsigned value to decimal ASCII characters, terminator last.
// A word is shifted through the shift-add-3 cell chain, then leading zero digits are dropped,
// then one character is emitted per digit, followed by the terminator.
// Results are registered; the next word can be accepted once the terminator has been produced,
// and capacity zero skips conversion and emits only the terminator.
// Synchronous active-low reset returns the block to idle with no strobe pending.
module uint64_to_decimal_ascii #(
    parameter int MAX_DIGITS = u2d_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  u2d_pkg::t_in   i_item,
    output logic           o_strobe,
    output u2d_pkg::t_out  o_result
);
    import u2d_pkg::*;

    localparam int DL_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ovf, n_ovf;
    logic [DL_W-1:0]     r_dleft, n_dleft;
    logic [CAP_W-1:0]    r_cleft, n_cleft;
    logic                r_strobe, n_strobe;
    t_out                r_result, n_result;

    t_cell_ctrl          ctrl;
    logic [MAX_DIGITS:0] w_bit;
    logic [DIGIT_W-1:0]  w_dig [MAX_DIGITS+1];
    logic [DIGIT_W-1:0]  top_digit;
    logic                accept;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign w_bit[0]  = r_val[VALUE_W-1];
    assign w_dig[0]  = '0;
    assign top_digit = w_dig[MAX_DIGITS];

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        u2d_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_bit   (w_bit[g]),
            .i_digit (w_dig[g]),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_dig[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_dleft  = r_dleft;
        n_cleft  = r_cleft;
        n_strobe = 1'b0;
        n_result = r_result;
        ctrl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ctrl.clear = 1'b1;
                    n_val      = i_item.value;
                    n_cnt      = '0;
                    n_ovf      = 1'b0;
                    n_cleft    = i_item.capacity;
                    n_dleft    = '0;
                    n_state    = (i_item.capacity == '0) ? S_EMIT : S_CONV;
                end
            end
            S_CONV: begin
                ctrl.bit_shift = 1'b1;
                n_val          = {r_val[VALUE_W-2:0], 1'b0};
                n_ovf          = r_ovf | w_bit[MAX_DIGITS];
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_dleft = DL_W'(MAX_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_ovf || (top_digit != '0) || (r_dleft == DL_W'(1))) begin
                    n_state = S_EMIT;
                end else begin
                    ctrl.dig_shift = 1'b1;
                    n_dleft        = r_dleft - 1'b1;
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                if ((r_dleft != '0) && (r_cleft > CAP_W'(1))) begin
                    ctrl.dig_shift   = 1'b1;
                    n_dleft          = r_dleft - 1'b1;
                    n_cleft          = r_cleft - 1'b1;
                    n_result.out_char = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    n_result.written  = 1'b1;
                    n_result.last     = 1'b0;
                end else begin
                    n_result.out_char = CHAR_NUL;
                    n_result.written  = (r_cleft != '0);
                    n_result.last     = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_val    <= n_val;
        r_cnt    <= n_cnt;
        r_ovf    <= n_ovf;
        r_dleft  <= n_dleft;
        r_cleft  <= n_cleft;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- hdl/u2d_checker.sv -----
// Port-level checker for the decimal ASCII converter, bound to the top level.
`include "assert_macros.svh"

module u2d_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input u2d_pkg::t_out o_result,
    input logic          o_strobe
);
    import u2d_pkg::*;

    `CHK_NEXT(a_accept_busy, start && !busy, busy)
    `CHK_NEXT(a_accept_quiet, start && !busy, !o_strobe)
    `CHK_IMPLIES(a_mid_busy, o_strobe && !o_result.last, busy)
    `CHK_IMPLIES(a_unwritten_last, o_strobe && !o_result.written, o_result.last)
    `CHK_IMPLIES(a_last_nul, o_strobe && o_result.last, o_result.out_char == CHAR_NUL)

endmodule

bind uint64_to_decimal_ascii u2d_checker u_chk (.*);
